// ===== src/mdl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdl_pkg
// Widths and constants shared by the modulated delay line.
// ----------------------------------------------------------------------------
package mdl_pkg;

  localparam int MAX_LENGTH = 4096;
  localparam int ADDR_W     = $clog2(MAX_LENGTH);
  localparam int LEN_W      = ADDR_W + 1;
  localparam int DATA_W     = 16;
  localparam int PROD_W     = DATA_W + LEN_W;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = FIFO_AW + 1;

  localparam logic [LEN_W-1:0]  LEN_RESET = LEN_W'(1024);
  localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(MAX_LENGTH);
  localparam logic [PROD_W:0]   ROUND_HALF = (PROD_W + 1)'(32768);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [DATA_W-1:0] data_t;

endpackage

// ===== src/modulated_delay_line_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modulated_delay_line_top
// Vibrato delay line: writes each sample into a ring and returns the sample
// that lies a phase-modulated lag back, rounded half up and clamped.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while in_tready is high; the ring memory
// takes one write and one read each cycle, and an 8-entry output queue
// absorbs output stalls.
// Reset (rst_n, synchronous): pipeline, queue, write position and fill count
// clear, delay_length returns to 1024. Entries at or above the fill count
// read as silence, so no clearing pass over the ring is needed.
module modulated_delay_line_top
  import mdl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,    // [15:0] sample_in, [31:16] mod_phase
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,   // [15:0] sample_out
  input  logic              cfg_wr_en,
  input  logic [LEN_W-1:0]  cfg_wr_data  // delay_length
);

  logic in_fire, out_fire;

  // Configuration and write pointer state.
  len_t  len_r;
  addr_t wp_r, wp_nxt;
  len_t  len_eff, wp_inc;
  addr_t wp_eff;
  logic [DATA_W-1:0] biased;

  // Stage 1: product.
  logic              s1_v_r;
  logic [PROD_W-1:0] s1_prod_r;
  data_t             s1_sample_r;
  addr_t             s1_wp_r;
  len_t              s1_len_r;

  // Stage 2: clamped lag, ring access.
  logic              s2_v_r;
  addr_t             s2_lag_r;
  data_t             s2_sample_r;
  addr_t             s2_wp_r;
  len_t              s2_len_r;
  len_t              lag_raw, len_m1, rd_full, hw_r, wp_plus1;
  addr_t             rd_addr;
  logic              fwd, zero;

  // Stage 3: read data.
  logic  s3_v_r, s3_fwd_r, s3_zero_r;
  data_t s3_sample_r, rdata_r, s3_value;

  data_t ring_mem [0:MAX_LENGTH-1];

  // Output queue.
  data_t               fifo_mem [0:FIFO_DEPTH-1];
  logic [FIFO_AW-1:0]  fifo_wr_r, fifo_rd_r;
  logic [CNT_W-1:0]    fifo_cnt_r, busy_cnt_r;

  assign in_tready  = (busy_cnt_r != CNT_W'(FIFO_DEPTH));
  assign in_fire    = in_tvalid & in_tready;
  assign out_tvalid = (fifo_cnt_r != '0);
  assign out_fire   = out_tvalid & out_tready;
  assign out_tdata  = fifo_mem[fifo_rd_r];

  always_comb begin
    if (len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_r > LEN_MAX) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = len_r;
    end
    wp_eff = ({1'b0, wp_r} >= len_eff) ? '0 : wp_r;
    wp_inc = {1'b0, wp_eff} + LEN_W'(1);
    wp_nxt = (wp_inc >= len_eff) ? '0 : wp_inc[ADDR_W-1:0];
    // Adding 1.0 in Q1.15 is the same as flipping the sign bit.
    biased = {~in_tdata[31], in_tdata[30:16]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_RESET;
      wp_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        len_r <= cfg_wr_data;
      end
      if (in_fire) begin
        wp_r <= wp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_fire;
    end
    s1_prod_r   <= PROD_W'(biased) * PROD_W'(len_eff);
    s1_sample_r <= in_tdata[15:0];
    s1_wp_r     <= wp_eff;
    s1_len_r    <= len_eff;
  end

  always_comb begin
    lag_raw = LEN_W'(((PROD_W + 1)'(s1_prod_r) + ROUND_HALF) >> 16);
    len_m1  = s1_len_r - LEN_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
    s2_lag_r    <= (lag_raw > len_m1) ? len_m1[ADDR_W-1:0] : lag_raw[ADDR_W-1:0];
    s2_sample_r <= s1_sample_r;
    s2_wp_r     <= s1_wp_r;
    s2_len_r    <= s1_len_r;
  end

  always_comb begin
    if (s2_wp_r >= s2_lag_r) begin
      rd_full = {1'b0, s2_wp_r} - {1'b0, s2_lag_r};
    end else begin
      rd_full = {1'b0, s2_wp_r} + s2_len_r - {1'b0, s2_lag_r};
    end
    rd_addr  = rd_full[ADDR_W-1:0];
    fwd      = (s2_lag_r == '0);
    // Entries at or above the fill count have never been written.
    zero     = !fwd && (rd_full >= hw_r);
    wp_plus1 = {1'b0, s2_wp_r} + LEN_W'(1);
  end

  // Fill count: writes always form a prefix of the ring, since the write
  // position only steps by one or restarts at zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r <= '0;
    end else if (s2_v_r && (wp_plus1 > hw_r)) begin
      hw_r <= wp_plus1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      ring_mem[s2_wp_r] <= s2_sample_r;
    end
    rdata_r <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
    s3_fwd_r    <= fwd;
    s3_zero_r   <= zero;
    s3_sample_r <= s2_sample_r;
  end

  // A lag of zero returns the sample written in the same cycle.
  always_comb begin
    if (s3_fwd_r) begin
      s3_value = s3_sample_r;
    end else if (s3_zero_r) begin
      s3_value = '0;
    end else begin
      s3_value = rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_v_r) begin
      fifo_mem[fifo_wr_r] <= s3_value;
    end
  end

  // The busy count covers requests in the pipeline and in the queue, so the
  // queue can never overflow.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_wr_r  <= '0;
      fifo_rd_r  <= '0;
      fifo_cnt_r <= '0;
      busy_cnt_r <= '0;
    end else begin
      if (s3_v_r) begin
        fifo_wr_r <= fifo_wr_r + FIFO_AW'(1);
      end
      if (out_fire) begin
        fifo_rd_r <= fifo_rd_r + FIFO_AW'(1);
      end
      fifo_cnt_r <= fifo_cnt_r + CNT_W'(s3_v_r) - CNT_W'(out_fire);
      busy_cnt_r <= busy_cnt_r + CNT_W'(in_fire) - CNT_W'(out_fire);
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the vibrato delay line. A software ring image
// predicts every delayed sample as requests are accepted, and each returned
// sample is compared in order. Directed cases cover the phase and sample
// extremes and the odd delay lengths. Random phases follow over many lengths,
// with random gaps on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top
  import mdl_pkg::*;
();

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [15:0] PHASE_MIN = 16'h8000;
  localparam logic [15:0] PHASE_MAX = 16'h7FFF;
  localparam logic [15:0] PHASE_MID = 16'h0000;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [31:0]      in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [15:0]      out_tdata;
  logic             cfg_wr_en;
  logic [LEN_W-1:0] cfg_wr_data;

  // Mirror of the block's state.
  logic [15:0]      ring_image [MAX_LENGTH];
  int unsigned      write_slot;
  logic [12:0]      length_reg;

  logic [15:0]      expected_samples [$];
  int               errors;
  int               cycle_count;
  bit               sender_gaps;
  bit               receiver_stalls;
  bit               long_hold_pending;
  logic [15:0]      want_sample;

  modulated_delay_line_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("%0t: timeout, %0d samples still expected", $time,
                 expected_samples.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Advances the ring image by one request and returns the delayed sample.
  function automatic logic [15:0] vibrato_step(input logic [15:0] sample,
                                               input logic [15:0] phase);
    int unsigned     len;
    longint unsigned biased;
    longint unsigned lag;
    int unsigned     rd_slot;
    len = length_reg;
    if (len < 1) len = 1;
    if (len > MAX_LENGTH) len = MAX_LENGTH;
    // Flipping the sign bit adds 1.0 to the phase.
    biased = longint'(phase ^ 16'h8000);
    lag = (biased * len + 32768) >> 16;
    if (lag > len - 1) lag = len - 1;
    if (write_slot >= len) write_slot = 0;
    if (write_slot >= lag) rd_slot = write_slot - int'(lag);
    else rd_slot = write_slot + len - int'(lag);
    ring_image[write_slot] = sample;
    write_slot++;
    if (write_slot >= len) write_slot = 0;
    return ring_image[rd_slot];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Output side: random stalls, plus one long hold-off on demand.
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && receiver_stalls && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_samples.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual sample_out %h",
                 $time, out_tdata);
      end else begin
        want_sample = expected_samples.pop_front();
        if (out_tdata !== want_sample) begin
          errors++;
          $display("%0t: sample_out mismatch, expected %h, actual %h",
                   $time, want_sample, out_tdata);
        end
      end
    end
  end

  // Starts and ends at a falling edge.
  task automatic send_request(input logic [15:0] sample, input logic [15:0] phase);
    int gap;
    gap = sender_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {phase, sample};
    do @(posedge clk); while (!in_tready);
    expected_samples.push_back(vibrato_step(sample, phase));
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_delay_length(input logic [12:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    length_reg  = value;
  endtask

  function automatic logic [15:0] random_phase();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return PHASE_MIN;
    if (r < 16) return PHASE_MAX;
    return 16'($urandom);
  endfunction

  // Reset length 1024: forwarding at phase -1.0, clamp near +1.0, unwritten
  // entries reading as silence.
  task automatic test_directed_extremes();
    send_request(16'h7FFF, PHASE_MIN);
    send_request(16'h8000, PHASE_MIN);
    send_request(16'hFFFF, PHASE_MIN);
    send_request(16'h0000, PHASE_MIN);
    send_request(16'h1234, PHASE_MAX);
    send_request(16'h5A5A, PHASE_MID);
    send_request(16'hA5A5, 16'hFFFF);
    send_request(16'h0001, 16'h0001);
    drain_results();
  endtask

  // Shrinking below the write position restarts it; old contents stay.
  task automatic test_shortened_length();
    write_delay_length(13'd3);
    send_request(16'h1111, PHASE_MAX);
    send_request(16'h2222, PHASE_MAX);
    send_request(16'h3333, PHASE_MID);
    send_request(16'h4444, PHASE_MIN);
    drain_results();
    write_delay_length(13'd1024);
    send_request(16'h5555, 16'hC000);
    drain_results();
  endtask

  task automatic test_degenerate_lengths();
    write_delay_length(13'd0);
    send_request(16'h7FFF, PHASE_MAX);
    send_request(16'h8000, PHASE_MID);
    send_request(16'hC3C3, PHASE_MIN);
    drain_results();
    write_delay_length(13'd1);
    send_request(16'h0F0F, PHASE_MAX);
    send_request(16'hF0F0, PHASE_MIN);
    drain_results();
  endtask

  task automatic test_oversize_length();
    write_delay_length(13'h1FFF);
    send_request(16'h6789, PHASE_MAX);
    send_request(16'h9876, PHASE_MID);
    drain_results();
    write_delay_length(13'd4096);
    send_request(16'h4321, PHASE_MAX);
    send_request(16'hBEEF, 16'h8001);
    drain_results();
  endtask

  // Mostly short lines so that reads land on samples written in this run.
  task automatic test_random_vibrato();
    int          r;
    logic [12:0] len;
    for (int p = 0; p < 9; p++) begin
      r = $urandom_range(0, 99);
      if (p == 0) len = 13'd4096;
      else if (r < 10) len = 13'($urandom_range(0, 1));
      else if (r < 15) len = 13'($urandom_range(4097, 8191));
      else if (r < 75) len = 13'($urandom_range(2, 64));
      else len = 13'($urandom_range(65, 300));
      write_delay_length(len);
      sender_gaps     = (p != 4);
      receiver_stalls = (p != 4);
      for (int i = 0; i < 60; i++) send_request(16'($urandom), random_phase());
      drain_results();
    end
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  // The output holds off long enough for the output queue to fill up.
  task automatic test_output_backpressure();
    write_delay_length(13'd37);
    sender_gaps       = 1'b0;
    long_hold_pending = 1'b1;
    for (int i = 0; i < 60; i++) send_request(16'($urandom), random_phase());
    drain_results();
    sender_gaps = 1'b1;
  endtask

  initial begin
    errors            = 0;
    sender_gaps       = 1'b1;
    receiver_stalls   = 1'b1;
    long_hold_pending = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    foreach (ring_image[i]) ring_image[i] = '0;
    write_slot = 0;
    length_reg = 13'd1024;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_extremes();
    test_shortened_length();
    test_degenerate_lengths();
    test_oversize_length();
    test_random_vibrato();
    test_output_backpressure();

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
